[design/vrt_pkg.sv]
// shared types and constants for the voxel ray traversal core
// no dependencies
`default_nettype none
package vrt_pkg;
    localparam int DIST_W = 40;
    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
    localparam int ROOT_W = 24;
    localparam int JOB_W = 3;
    localparam logic [JOB_W-1:0] JOB_BND_X = 3'd0;
    localparam logic [JOB_W-1:0] JOB_STP_X = 3'd3;
    localparam logic [JOB_W-1:0] JOB_LIMIT = 3'd6;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_HIT   = 2'd1,
        KIND_MISS  = 2'd2
    } kind_t;

    typedef struct packed {
        logic             load_start;
        logic             answer;
        logic             sq_en;
        logic [1:0]       sq_idx;
        logic             root_start;
        logic             div_start;
        logic             div_store;
        logic [JOB_W-1:0] job;
    } ctrl_t;

    typedef struct packed {
        logic root_done;
        logic div_done;
        logic out_free;
    } stat_t;
endpackage
`default_nettype wire

[design/vrt_datapath.sv]
// datapath: ray state, answer step, squarer, root unit, shared divider unit, result register
// depends on vrt_pkg
`default_nettype none
module vrt_datapath #(
    parameter int COORD_BITS = 16,
    parameter int DIST_FRAC_BITS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  vrt_pkg::ctrl_t      ctrl,
    output vrt_pkg::stat_t      stat,
    input  wire  [183:0]        s_tdata,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [55:0]         m_tdata,
    output logic [1:0]          m_tuser
);
    import vrt_pkg::*;

    localparam int NUM_W = DIST_FRAC_BITS + 38;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [COORD_BITS-1:0] cur_reg [3], cur_next [3];
    logic [2:0]            neg_reg, neg_next;
    logic [DIST_W-1:0]     bnd_reg [3], bnd_next [3];
    logic [DIST_W-1:0]     stp_reg [3], stp_next [3];
    logic [DIST_W-1:0]     limit_reg, limit_next;
    logic [2:0]            face_reg, face_next;
    logic                  walk_reg, walk_next;
    logic [15:0]           mag_reg [3], mag_next [3];
    logic [16:0]           bnum_reg [3], bnum_next [3];
    logic [31:0]           reach_reg, reach_next;
    logic [31:0]           acc_reg, acc_next;

    logic [47:0]           rv_reg, rv_next;
    logic [25:0]           rrem_reg, rrem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [4:0]            rcnt_reg, rcnt_next;
    logic                  rbusy_reg, rbusy_next, rdone_reg, rdone_next;

    logic [NUM_W-1:0]      dnum_reg, dnum_next;
    logic [ROOT_W-1:0]     dden_reg, dden_next;
    logic [ROOT_W-1:0]     drem_reg, drem_next;
    logic [CNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                  dbusy_reg, dbusy_next, ddone_reg, ddone_next;

    logic                  mvalid_reg, mvalid_next;
    logic [1:0]            mkind_reg, mkind_next;
    logic [15:0]           mvox_reg [3], mvox_next [3];
    logic [2:0]            mface_reg, mface_next;

    logic [31:0]           org [3];
    logic [15:0]           dir [3];
    logic [31:0]           ip32 [3];
    logic [31:0]           wide [3];
    logic [31:0]           swide [3];
    logic [15:0]           dmag [3];
    logic [1:0]            ax;
    logic [DIST_W:0]       bsum;
    logic [25:0]           rsh, rtrial;
    logic [ROOT_W:0]       dsh;
    logic                  dge;
    logic [NUM_W-1:0]      job_num;
    logic [ROOT_W-1:0]     job_den;
    logic [DIST_W-1:0]     qsat;
    logic [1:0]            jax;
    logic                  jzero;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            org[i]   = s_tdata[32*i +: 32];
            dir[i]   = s_tdata[96 + 16*i +: 16];
            ip32[i]  = {{16{org[i][31]}}, org[i][31:16]};
            dmag[i]  = dir[i][15] ? 16'(17'h10000 - {1'b0, dir[i]}) : dir[i];
            wide[i]  = 32'(cur_reg[i]);
            swide[i] = 32'(ip32[i][COORD_BITS-1:0]);
        end
    end

    always_comb
    begin
        if (bnd_reg[0] < bnd_reg[1])
            ax = (bnd_reg[0] < bnd_reg[2]) ? 2'd0 : 2'd2;
        else
            ax = (bnd_reg[1] < bnd_reg[2]) ? 2'd1 : 2'd2;
        bsum = {1'b0, bnd_reg[ax]} + {1'b0, stp_reg[ax]};
    end

    always_comb
    begin
        jax   = 2'd0;
        jzero = 1'b0;
        job_num = '0;
        job_den = '0;
        case (ctrl.job)
            3'd0, 3'd1, 3'd2:
            begin
                jax = ctrl.job[1:0];
                job_num = NUM_W'(bnum_reg[jax]) << (DIST_FRAC_BITS - 2);
                job_den = ROOT_W'(mag_reg[jax]);
                jzero = (mag_reg[jax] == 16'd0);
            end
            3'd3, 3'd4, 3'd5:
            begin
                jax = 2'(ctrl.job - JOB_STP_X);
                job_num = NUM_W'(1) << (14 + DIST_FRAC_BITS);
                job_den = ROOT_W'(mag_reg[jax]);
                jzero = (mag_reg[jax] == 16'd0);
            end
            default:
            begin
                job_num = NUM_W'(reach_reg) << (DIST_FRAC_BITS + 6);
                job_den = root_reg;
                jzero = (root_reg == '0);
            end
        endcase
        if (jzero || (dnum_reg[NUM_W-1:DIST_W] != '0))
            qsat = DIST_INF;
        else
            qsat = dnum_reg[DIST_W-1:0];
    end

    assign rsh    = {rrem_reg[23:0], rv_reg[47:46]};
    assign rtrial = {root_reg, 2'b01};
    assign dsh    = {drem_reg, dnum_reg[NUM_W-1]};
    assign dge    = dsh >= {1'b0, dden_reg};

    always_comb
    begin
        cur_next = cur_reg;
        neg_next = neg_reg;
        bnd_next = bnd_reg;
        stp_next = stp_reg;
        limit_next = limit_reg;
        face_next = face_reg;
        walk_next = walk_reg;
        mag_next = mag_reg;
        bnum_next = bnum_reg;
        reach_next = reach_reg;
        acc_next = acc_reg;
        rv_next = rv_reg;
        rrem_next = rrem_reg;
        root_next = root_reg;
        rcnt_next = rcnt_reg;
        rbusy_next = rbusy_reg;
        rdone_next = 1'b0;
        dnum_next = dnum_reg;
        dden_next = dden_reg;
        drem_next = drem_reg;
        dcnt_next = dcnt_reg;
        dbusy_next = dbusy_reg;
        ddone_next = 1'b0;
        mvalid_next = mvalid_reg && !m_tready;
        mkind_next = mkind_reg;
        mvox_next = mvox_reg;
        mface_next = mface_reg;

        if (ctrl.load_start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cur_next[i]  = ip32[i][COORD_BITS-1:0];
                neg_next[i]  = dir[i][15];
                mag_next[i]  = dmag[i];
                bnum_next[i] = (dir[i][15] || dir[i] == 16'd0) ? {1'b0, org[i][15:0]}
                             : 17'h10000 - {1'b0, org[i][15:0]};
                mvox_next[i] = swide[i][15:0];
            end
            reach_next  = s_tdata[175:144];
            acc_next    = '0;
            face_next   = 3'd0;
            walk_next   = 1'b1;
            mvalid_next = 1'b1;
            mkind_next  = KIND_QUERY;
            mface_next  = 3'd0;
        end
        else if (ctrl.answer && walk_reg)
        begin
            mvalid_next = 1'b1;
            if (s_tdata[176])
            begin
                walk_next = 1'b0;
                mkind_next = KIND_HIT;
                for (int i = 0; i < 3; i++)
                    mvox_next[i] = wide[i][15:0];
                mface_next = face_reg;
            end
            else if (bnd_reg[ax] == DIST_INF || bnd_reg[ax] > limit_reg || mag_reg[ax] == 16'd0)
            begin
                walk_next = 1'b0;
                mkind_next = KIND_MISS;
                for (int i = 0; i < 3; i++)
                    mvox_next[i] = 16'd0;
                mface_next = 3'd0;
            end
            else
            begin
                cur_next[ax] = neg_reg[ax] ? cur_reg[ax] - COORD_BITS'(1)
                                           : cur_reg[ax] + COORD_BITS'(1);
                bnd_next[ax] = (bsum >= {1'b0, DIST_INF}) ? DIST_INF : bsum[DIST_W-1:0];
                face_next = {ax, 1'b0} + (neg_reg[ax] ? 3'd1 : 3'd2);
                mkind_next = KIND_QUERY;
                for (int i = 0; i < 3; i++)
                    mvox_next[i] = wide[i][15:0];
                mvox_next[ax] = 16'(32'(cur_next[ax]));
                mface_next = face_next;
            end
        end

        if (ctrl.sq_en)
            acc_next = acc_reg + ({16'd0, mag_reg[ctrl.sq_idx]} * {16'd0, mag_reg[ctrl.sq_idx]});

        if (ctrl.root_start)
        begin
            rv_next = {acc_reg, 16'd0};
            rrem_next = '0;
            root_next = '0;
            rcnt_next = '0;
            rbusy_next = 1'b1;
        end
        else if (rbusy_reg)
        begin
            rv_next = {rv_reg[45:0], 2'b00};
            if (rsh >= rtrial)
            begin
                rrem_next = rsh - rtrial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rrem_next = rsh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            rcnt_next = rcnt_reg + 5'd1;
            if (rcnt_reg == 5'(ROOT_W - 1))
            begin
                rbusy_next = 1'b0;
                rdone_next = 1'b1;
            end
        end

        if (ctrl.div_start)
        begin
            dnum_next = job_num;
            dden_next = job_den;
            drem_next = '0;
            dcnt_next = '0;
            dbusy_next = 1'b1;
        end
        else if (dbusy_reg)
        begin
            dnum_next = {dnum_reg[NUM_W-2:0], dge};
            drem_next = dge ? ROOT_W'(dsh - {1'b0, dden_reg}) : dsh[ROOT_W-1:0];
            dcnt_next = dcnt_reg + CNT_W'(1);
            if (dcnt_reg == CNT_W'(NUM_W - 1))
            begin
                dbusy_next = 1'b0;
                ddone_next = 1'b1;
            end
        end

        if (ctrl.div_store)
        begin
            if (ctrl.job == JOB_LIMIT)
                limit_next = qsat;
            else if (ctrl.job < JOB_STP_X)
                bnd_next[jax] = qsat;
            else
                stp_next[jax] = qsat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i] <= '0;
                bnd_reg[i] <= '0;
                stp_reg[i] <= '0;
                mag_reg[i] <= '0;
            end
            neg_reg <= '0;
            limit_reg <= '0;
            face_reg <= '0;
            walk_reg <= 1'b0;
            rbusy_reg <= 1'b0;
            rdone_reg <= 1'b0;
            rcnt_reg <= '0;
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            bnd_reg <= bnd_next;
            stp_reg <= stp_next;
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            limit_reg <= limit_next;
            face_reg <= face_next;
            walk_reg <= walk_next;
            rbusy_reg <= rbusy_next;
            rdone_reg <= rdone_next;
            rcnt_reg <= rcnt_next;
            dbusy_reg <= dbusy_next;
            ddone_reg <= ddone_next;
            dcnt_reg <= dcnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bnum_reg <= bnum_next;
        reach_reg <= reach_next;
        acc_reg <= acc_next;
        rv_reg <= rv_next;
        rrem_reg <= rrem_next;
        root_reg <= root_next;
        dnum_reg <= dnum_next;
        dden_reg <= dden_next;
        drem_reg <= drem_next;
        mkind_reg <= mkind_next;
        mvox_reg <= mvox_next;
        mface_reg <= mface_next;
    end

    assign stat.root_done = rdone_reg;
    assign stat.div_done  = ddone_reg;
    assign stat.out_free  = !mvalid_reg || m_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mkind_reg;
    assign m_tdata  = {5'd0, mface_reg, mvox_reg[2], mvox_reg[1], mvox_reg[0]};
endmodule
`default_nettype wire

[design/vrt_ctrl.sv]
// controller: input handshake and sequencing of the start set-up jobs
// depends on vrt_pkg
`default_nettype none
module vrt_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    input  wire             s_cmd,
    output logic            s_tready,
    input  vrt_pkg::stat_t  stat,
    output vrt_pkg::ctrl_t  ctrl
);
    import vrt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SQ      = 6'b000010,
        S_ROOT_GO = 6'b000100,
        S_ROOT    = 6'b001000,
        S_DIV_GO  = 6'b010000,
        S_DIV     = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       idx_reg, idx_next;
    logic [JOB_W-1:0] job_reg, job_next;
    logic             accept;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        job_next = job_reg;
        ctrl = '0;
        ctrl.job = job_reg;
        ctrl.sq_idx = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.load_start = accept && !s_cmd;
                ctrl.answer = accept && s_cmd;
                if (accept && !s_cmd)
                begin
                    idx_next = 2'd0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                ctrl.sq_en = 1'b1;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                    state_next = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                ctrl.root_start = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (stat.root_done)
                begin
                    job_next = JOB_BND_X;
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                ctrl.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    ctrl.div_store = 1'b1;
                    job_next = job_reg + 3'd1;
                    state_next = (job_reg == JOB_LIMIT) ? S_IDLE : S_DIV_GO;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            job_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            job_reg <= job_next;
        end
    end
endmodule
`default_nettype wire

[design/voxel_ray_traversal_core.sv]
// voxel ray walk: ties the controller to the datapath
// depends on vrt_pkg, vrt_ctrl, vrt_datapath
//
// slave channel s_*: one word per item; s_tuser is the command (0 start ray,
// 1 occupancy answer for the voxel last queried). master channel m_*: one word
// per result, m_tuser is the kind (0 query, 1 hit, 2 miss).
// a start word yields the query for the start voxel in the result register in
// the cycle after it is accepted; set-up then squares the three direction
// magnitudes, runs a 24-step root and seven divisions of DIST_FRAC_BITS+38
// steps on one shared bit-serial divider, all with s_tready low.
// an answer word is a compare and add, its result registered in the cycle after
// it is accepted; the next word may follow at once: one answer per cycle while
// the walk runs and m_tready is high. answers with no walk in progress are
// dropped without a result. s_tready is low while a result waits and m_tready
// is low, so a stalled receiver holds the block with nothing lost.
// reset clears the walk state, sequencer and result valid flag; the block is
// ready on the first cycle after reset.
`default_nettype none
module voxel_ray_traversal_core #(
    parameter int COORD_BITS = 16,
    parameter int DIST_FRAC_BITS = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, reach, solid, zero pad
    input  wire  [183:0] s_tdata,
    // cmd
    input  wire          s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // voxel_x, voxel_y, voxel_z, face, zero pad
    output logic [55:0]  m_tdata,
    // kind
    output logic [1:0]   m_tuser
);
    import vrt_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    vrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    vrt_datapath #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("ready after start");
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> m_tvalid && m_tuser == KIND_QUERY)
        else $error("no query after start");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_MISS |-> m_tdata[50:0] == 51'd0)
        else $error("miss carries voxel");
`endif
endmodule
`default_nettype wire

[verif/vrt_checker.sv]
// checker for the voxel ray traversal core: watches both stream channels,
// predicts each result from the accepted words and compares field by field
// depends on vrt_pkg for kind_t
`default_nettype none
module vrt_checker (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [183:0] s_tdata,
    input  wire          s_tuser,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [55:0]  m_tdata,
    input  wire  [1:0]   m_tuser,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import vrt_pkg::*;

    localparam longint unsigned INF64 = (64'd1 << 40) - 64'd1;

    typedef struct {
        kind_t      kind;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic [2:0]  face;
    } walk_result_t;

    walk_result_t result_q[$];

    logic [15:0] voxel[3];
    int          dir_sign[3];
    logic [39:0] bnd[3];
    logic [39:0] stp[3];
    logic [39:0] limit;
    logic [2:0]  entry_face;
    bit          walking;

    function automatic logic [39:0] clamp_dist(input longint unsigned v);
        return (v > INF64) ? INF64[39:0] : v[39:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic walk_result_t make_result(input kind_t k, input bit with_voxel,
                                                 input logic [2:0] f);
        walk_result_t r;
        r.kind = k;
        r.vx = with_voxel ? voxel[0] : 16'd0;
        r.vy = with_voxel ? voxel[1] : 16'd0;
        r.vz = with_voxel ? voxel[2] : 16'd0;
        r.face = f;
        return r;
    endfunction

    task automatic start_ray(input logic [183:0] d);
        longint unsigned sq;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned norm;
        longint unsigned reach;
        logic [31:0] o;
        logic [15:0] draw;
        sq = 0;
        reach = d[175:144];
        for (int i = 0; i < 3; i++)
        begin
            o = d[32*i +: 32];
            draw = d[96 + 16*i +: 16];
            voxel[i] = o[31:16];
            if (draw == 16'd0)
            begin
                dir_sign[i] = 0;
                mag = 0;
            end
            else if (draw[15])
            begin
                dir_sign[i] = -1;
                mag = 64'h10000 - draw;
            end
            else
            begin
                dir_sign[i] = 1;
                mag = draw;
            end
            sq += mag * mag;
            if (mag == 0)
            begin
                bnd[i] = INF64[39:0];
                stp[i] = INF64[39:0];
            end
            else
            begin
                num = (dir_sign[i] > 0) ? (64'h10000 - o[15:0]) : o[15:0];
                bnd[i] = clamp_dist((num << 14) / mag);
                stp[i] = clamp_dist((64'd1 << 30) / mag);
            end
        end
        norm = int_sqrt(sq << 16);
        limit = (norm == 0) ? INF64[39:0] : clamp_dist((reach << 22) / norm);
        entry_face = 3'd0;
        walking = 1'b1;
        result_q.push_back(make_result(KIND_QUERY, 1'b1, 3'd0));
    endtask

    task automatic answer_voxel(input bit solid);
        int ax;
        if (!walking)
            return;
        if (solid)
        begin
            walking = 1'b0;
            result_q.push_back(make_result(KIND_HIT, 1'b1, entry_face));
            return;
        end
        if (bnd[0] < bnd[1])
            ax = (bnd[0] < bnd[2]) ? 0 : 2;
        else
            ax = (bnd[1] < bnd[2]) ? 1 : 2;
        if (bnd[ax] == INF64[39:0] || bnd[ax] > limit || dir_sign[ax] == 0)
        begin
            walking = 1'b0;
            result_q.push_back(make_result(KIND_MISS, 1'b0, 3'd0));
            return;
        end
        voxel[ax] = (dir_sign[ax] > 0) ? voxel[ax] + 16'd1 : voxel[ax] - 16'd1;
        bnd[ax] = clamp_dist(longint'(bnd[ax]) + longint'(stp[ax]));
        entry_face = 3'(ax * 2 + ((dir_sign[ax] > 0) ? 2 : 1));
        result_q.push_back(make_result(KIND_QUERY, 1'b1, entry_face));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                voxel[i] = '0;
                dir_sign[i] = 0;
                bnd[i] = '0;
                stp[i] = '0;
            end
            limit = '0;
            entry_face = '0;
            walking = 1'b0;
            result_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word: kind %0d data %h", m_tuser, m_tdata);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata[15:0] !== want.vx
                        || m_tdata[31:16] !== want.vy || m_tdata[47:32] !== want.vz
                        || m_tdata[50:48] !== want.face || m_tdata[55:51] !== 5'd0)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected kind %0d v %h %h %h face %0d, got kind %0d v %h %h %h face %0d pad %h",
                                     want.kind, want.vx, want.vy, want.vz, want.face,
                                     m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                     m_tdata[50:48], m_tdata[55:51]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == 1'b0)
                    start_ray(s_tdata);
                else
                    answer_voxel(s_tdata[176]);
            end
            pending = result_q.size();
        end
    end
endmodule
`default_nettype wire

[verif/tb_top.sv]
// top of the voxel ray traversal testbench: clock, reset, stimulus and verdict
// depends on vrt_pkg, voxel_ray_traversal_core and vrt_checker
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [183:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           pending;
    bit           calm;
    int           sent;

    voxel_ray_traversal_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    vrt_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4ms;
        $display("voxel_ray_traversal_core test failed");
        $finish;
    end

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 32);

    function automatic logic [183:0] ray_word(input logic [31:0] ox, oy, oz,
                                              input logic [15:0] dx, dy, dz,
                                              input logic [31:0] reach, input bit solid);
        return {7'd0, solid, reach, dz, dy, dx, oz, oy, ox};
    endfunction

    task automatic send_word(input bit cmd, input logic [183:0] d);
        while (!calm && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic answer(input bit solid);
        send_word(1'b1, 184'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom})
                        & ~(184'd1 << 176) | (184'(solid) << 176));
    endtask

    function automatic logic [15:0] rand_dir();
        return ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_origin();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    initial
    begin
        int steps;
        logic [31:0] reach;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        calm = 1'b0;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // answers with no walk in progress
        answer(1'b0);
        answer(1'b1);
        // most negative origin and direction, full reach
        send_word(1'b0, ray_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 1'b0));
        answer(1'b0);
        answer(1'b0);
        answer(1'b0);
        answer(1'b1);
        // all-zero direction: walk never leaves the start voxel
        send_word(1'b0, ray_word(32'h0001_2345, 32'hFFFF_0000, 32'h0, 16'd0, 16'd0, 16'd0,
                                 32'd0, 1'b0));
        answer(1'b0);
        // largest origin and direction, zero reach
        send_word(1'b0, ray_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd0, 1'b1));
        answer(1'b0);
        // hit on the start voxel
        send_word(1'b0, ray_word(32'h0000_8000, 32'h0, 32'h0, 16'h4000, 16'd0, 16'd0,
                                 32'h0010_0000, 1'b0));
        answer(1'b1);
        // coordinate wrap along +x, origin exactly on a y boundary
        send_word(1'b0, ray_word(32'h7FFF_8000, 32'h0005_0000, 32'h0, 16'h4000, 16'h0001,
                                 16'd0, 32'hFFFF_FFFF, 1'b0));
        answer(1'b0);
        answer(1'b0);
        answer(1'b0);
        answer(1'b0);
        answer(1'b1);

        while (sent < 1000)
        begin
            calm = (sent > 450 && sent < 600);
            if ($urandom_range(99) < 85)
            begin
                reach = ($urandom_range(2) == 0) ? $urandom : $urandom_range(32'h0020_0000);
                send_word(1'b0, ray_word(rand_origin(), rand_origin(), rand_origin(),
                                         rand_dir(), rand_dir(), rand_dir(), reach,
                                         $urandom_range(1)));
                steps = $urandom_range(20, 1);
                repeat (steps)
                    answer($urandom_range(99) < 8);
            end
            else
                send_word($urandom_range(1),
                          184'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("voxel_ray_traversal_core test passed");
        else
            $display("voxel_ray_traversal_core test failed");
        $finish;
    end
endmodule
`default_nettype wire
